// ===== src/plrc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the position limit risk check.
// No dependencies; imported by the core.
package plrc_pkg;

	// Fixed field widths
	localparam int unsigned WORD_W = 32;
	localparam int unsigned SYM_W  = 64;

	// Modulo reduction of the hash: four hash bits per cycle
	localparam int unsigned MOD_BITS  = 4;
	localparam int unsigned MOD_STEPS = WORD_W / MOD_BITS;

	typedef logic [2:0] mode_t;

	// Item modes
	localparam mode_t MODE_FULL  = 3'd0;
	localparam mode_t MODE_POS   = 3'd1;
	localparam mode_t MODE_FILL  = 3'd2;
	localparam mode_t MODE_SET   = 3'd3;
	localparam mode_t MODE_QUERY = 3'd4;

	// One table entry as stored in memory
	typedef struct packed {
		logic [WORD_W-1:0] net_limit;
		logic [WORD_W-1:0] short_total;
		logic [WORD_W-1:0] long_total;
	} entry_t;

	// Symbol hash step: h * 31 + b, wrapping at 32 bits
	function automatic logic [WORD_W-1:0] hash_step(input logic [WORD_W-1:0] h,
			input logic [7:0] b);
		hash_step = (h << 5) - h + {{(WORD_W-8){1'b0}}, b};
	endfunction

endpackage

// ===== src/plrc_ram.sv =====
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module plrc_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic                                  rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== src/position_limit_risk_check_core.sv =====
`timescale 1ns / 1ps
// Top level of the pre-trade position limit check over a hashed symbol table.
// Depends on plrc_pkg and plrc_ram.

// An item is taken when start is high and busy is low; its one result appears
// on accepted and net_position, flagged by done for a single cycle, and must
// be captured then since it cannot be held off. The symbol is hashed one byte
// per cycle in ST_HASH, over its leading nonzero bytes plus one, capped at
// SYMBOL_BYTES. For a TABLE_ENTRIES that is not a power of two the hash is
// then reduced modulo the table size in ST_MOD, four bits a cycle. Then
// ST_READ reads the entry from the table memory, ST_EXEC checks and writes
// it back and ST_OUT forms the net position; done is registered in ST_OUT,
// and a new item may be started in the cycle done is high. After reset the
// table is cleared one entry per cycle, so busy stays high until every entry
// has been cleared. The breaker_active flag, held in breaker_q, is written
// through cfg_wr_en and cfg_wr_data; the user is to write it only while the
// block is idle, and the block itself does not enforce this.
module position_limit_risk_check_core #(
	parameter int TABLE_ENTRIES = 256,
	parameter int SYMBOL_BYTES  = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic                  cfg_wr_data,
	input  logic                  start,
	output logic                  busy,
	input  plrc_pkg::mode_t       mode,
	input  logic [63:0]           symbol_chars,
	input  logic                  buy_side,
	input  logic [31:0]           quantity,
	input  logic signed [31:0]    price,
	input  logic [31:0]           limit_value,
	output logic                  done,
	output logic                  accepted,
	output logic signed [32:0]    net_position
);

	import plrc_pkg::*;

	localparam int IDX_W   = $clog2(TABLE_ENTRIES);
	localparam int CNT_W   = (SYMBOL_BYTES > 1) ? $clog2(SYMBOL_BYTES) : 1;
	localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
	localparam logic [IDX_W:0]   N_C       = (IDX_W + 1)'(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [CNT_W-1:0] LAST_BYTE = CNT_W'(SYMBOL_BYTES - 1);
	localparam int MCNT_W = $clog2(MOD_STEPS);
	localparam logic [MCNT_W-1:0] LAST_MOD = MCNT_W'(MOD_STEPS - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_MOD,
		ST_READ,
		ST_EXEC,
		ST_OUT
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   clr_q;
	logic               breaker_q;

	// Latched item
	mode_t              mode_q;
	logic [SYM_W-1:0]   sym_q;
	logic               buy_q;
	logic [WORD_W-1:0]  qty_q;
	logic               price_neg_q;
	logic [WORD_W-1:0]  limv_q;

	// Hash and index
	logic [WORD_W-1:0]  hash_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [MCNT_W-1:0]  mcnt_q;
	logic [IDX_W-1:0]   rem_q;
	logic [IDX_W-1:0]   idx_q;

	// Execute results
	logic [WORD_W-1:0]  lng_s2;
	logic [WORD_W-1:0]  sht_s2;
	logic               acc_s2;

	// Memory port
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	entry_t             ram_wdata;
	entry_t             ram_rdata;

	// Combinational helpers
	logic [7:0]         cur_byte;
	logic [WORD_W-1:0]  hash_next;
	logic [WORD_W-1:0]  hash_final;
	logic               hash_last;
	logic [IDX_W-1:0]   rem_next;
	logic [IDX_W:0]     rem_t;
	entry_t             ent_next;
	logic [WORD_W:0]    buy_lhs;
	logic [WORD_W:0]    buy_rhs;
	logic [WORD_W:0]    sell_lhs;
	logic [WORD_W:0]    sell_rhs;
	logic               pos_ok;
	logic               acc_next;

	assign busy = (state_q != ST_IDLE);

	// Hash one byte per cycle; stop at a zero byte or the byte limit
	always_comb begin
		cur_byte   = sym_q[7:0];
		hash_next  = hash_step(hash_q, cur_byte);
		hash_final = (cur_byte == 8'd0) ? hash_q : hash_next;
		hash_last  = (cur_byte == 8'd0) || (cnt_q == LAST_BYTE);
	end

	// Reduce the hash modulo the table size, MOD_BITS bits per cycle
	always_comb begin
		rem_next = rem_q;
		rem_t    = '0;
		for (int k = 0; k < MOD_BITS; k++) begin
			rem_t = {rem_next, hash_q[WORD_W-1-k]};
			if (rem_t >= N_C) begin
				rem_t = rem_t - N_C;
			end
			rem_next = rem_t[IDX_W-1:0];
		end
	end

	// Check limits in exact wide arithmetic and form the updated entry
	always_comb begin
		buy_lhs  = {1'b0, ram_rdata.long_total} + {1'b0, qty_q};
		buy_rhs  = {1'b0, ram_rdata.net_limit} + {1'b0, ram_rdata.short_total};
		sell_lhs = {1'b0, ram_rdata.long_total} + {1'b0, ram_rdata.net_limit};
		sell_rhs = {1'b0, ram_rdata.short_total} + {1'b0, qty_q};
		pos_ok   = buy_q ? (buy_lhs <= buy_rhs) : (sell_lhs >= sell_rhs);

		ent_next = ram_rdata;
		acc_next = 1'b0;
		case (mode_q) inside
			MODE_FULL: begin
				acc_next = !breaker_q && (qty_q != '0) && !price_neg_q && pos_ok;
			end
			MODE_POS: begin
				acc_next = pos_ok;
			end
			MODE_FILL: begin
				acc_next = 1'b1;
				if (buy_q) begin
					ent_next.long_total = ram_rdata.long_total + qty_q;
				end else begin
					ent_next.short_total = ram_rdata.short_total + qty_q;
				end
			end
			MODE_SET: begin
				acc_next = 1'b1;
				ent_next.net_limit = limv_q;
			end
			MODE_QUERY: begin
				acc_next = 1'b1;
			end
			default: begin
				acc_next = 1'b0;
			end
		endcase
	end

	// Memory write: clearing pass after reset, else write back on fill or set
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = (state_q == ST_EXEC) && (mode_q == MODE_FILL || mode_q == MODE_SET);
			ram_waddr = idx_q;
			ram_wdata = ent_next;
		end
	end

	plrc_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (state_q == ST_READ),
		.rd_addr (idx_q),
		.rd_data (ram_rdata)
	);

	// Control state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			breaker_q <= 1'b0;
			cnt_q     <= '0;
			mcnt_q    <= '0;
			done      <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_wr_en) begin
				breaker_q <= cfg_wr_data;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						mode_q      <= mode;
						sym_q       <= symbol_chars;
						buy_q       <= buy_side;
						qty_q       <= quantity;
						price_neg_q <= price[31];
						limv_q      <= limit_value;
						hash_q      <= '0;
						cnt_q       <= '0;
						state_q     <= ST_HASH;
					end
				end
				ST_HASH: begin
					hash_q <= hash_final;
					sym_q  <= sym_q >> 8;
					cnt_q  <= cnt_q + 1'b1;
					if (hash_last) begin
						if (IS_POW2) begin
							idx_q   <= hash_final[IDX_W-1:0];
							state_q <= ST_READ;
						end else begin
							rem_q   <= '0;
							mcnt_q  <= '0;
							state_q <= ST_MOD;
						end
					end
				end
				ST_MOD: begin
					rem_q  <= rem_next;
					hash_q <= hash_q << MOD_BITS;
					mcnt_q <= mcnt_q + 1'b1;
					if (mcnt_q == LAST_MOD) begin
						idx_q   <= rem_next;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					lng_s2  <= ent_next.long_total;
					sht_s2  <= ent_next.short_total;
					acc_s2  <= acc_next;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					accepted     <= acc_s2;
					net_position <= $signed({1'b0, lng_s2}) - $signed({1'b0, sht_s2});
					done         <= 1'b1;
					state_q      <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// A result beat never repeats in the next cycle
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// An accepted item keeps the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy did not rise after an accepted item");

	// Only fills and limit updates write the table outside the clearing pass
	a_write_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q != ST_CLEAR) |-> (mode_q == MODE_FILL || mode_q == MODE_SET))
		else $error("table written by a mode that must not change it");

	// Query always accepts, undefined modes never do
	a_query_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(done && mode_q == MODE_QUERY) |-> accepted)
		else $error("query result not accepted");

	a_bad_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(done && mode_q > MODE_QUERY) |-> !accepted)
		else $error("undefined mode accepted");

	// No results while the table is being cleared
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !done)
		else $error("result during clearing pass");
`endif

endmodule
